[rtl/core/multi_joint_slew_interpolator_macros.svh]
// assertion macros for the multi-joint slew interpolator
// no dependencies; taken in by files that carry concurrent checks
`ifndef MULTI_JOINT_SLEW_INTERPOLATOR_MACROS_SVH
`define MULTI_JOINT_SLEW_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge outside reset
`define MJSI_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mjsi check failed");
// condition in one cycle implies an outcome in the next
`define MJSI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mjsi check failed");
`else
`define MJSI_ASSERT(label, clk, rst_n, prop)
`define MJSI_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

[rtl/core/mjsi_pkg.sv]
// shared types and constants for the multi-joint slew interpolator
// no dependencies
`default_nettype none

package mjsi_pkg;

    // operation codes carried on the input tuser
    localparam logic [2:0] OP_SET_TARGET = 3'd0;
    localparam logic [2:0] OP_TICK       = 3'd1;
    localparam logic [2:0] OP_MOVE_NOW   = 3'd2;
    localparam logic [2:0] OP_STOP       = 3'd3;
    localparam logic [2:0] OP_RELEASE    = 3'd4;
    localparam logic [2:0] OP_READ       = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_ACTIVE_COUNT = 3'd0;
    localparam logic [2:0] CFG_STEP_SIZE    = 3'd1;
    localparam logic [2:0] CFG_HARD_MIN     = 3'd2;
    localparam logic [2:0] CFG_HARD_MAX     = 3'd3;
    localparam logic [2:0] CFG_OFFSETS      = 3'd4;
    localparam logic [2:0] CFG_VELOCITIES   = 3'd5;

    localparam int CFG_W = 60;

    localparam logic [47:0] HARD_MAX_RESET = 48'hB4B4_B4B4_B4B4;
    localparam logic [59:0] VELOCITY_RESET = {6{10'd60}};
    localparam logic [7:0]  STEP_RESET     = 8'd2;

    typedef logic signed [9:0]  t_angle;
    typedef logic signed [11:0] t_wide;

    localparam t_angle HOME_ANGLE = 10'sd90;
    localparam t_wide  SERVO_MAX  = 12'sd180;

    // degrees per 20 ms frame from degrees per second: v / 50, exact for 10-bit v
    function automatic logic [4:0] frame_step(input logic [9:0] v);
        logic [20:0] prod;
        prod = 21'(v) * 21'd1311;
        return prod[20:16];
    endfunction

endpackage

`default_nettype wire

[rtl/core/multi_joint_slew_interpolator.sv]
// Multi-joint slew interpolator. Current and target angles live in two small
// synchronous memories (registered read) indexed by joint. Set target, stop,
// release and unused operations give one status word; a read gives one word.
// A tick or move-at-once sweeps the active joints through the memories at
// one joint per cycle, buffers the servo writes and then sends them at one
// word per cycle while the output is taken; when halted, with no active joint,
// or for a tick with no motion, it gives one status word instead. No clearing
// pass: per-entry valid bits give the home angle until a joint is written.
// depends on mjsi_pkg and multi_joint_slew_interpolator_macros.svh
`default_nettype none

`include "multi_joint_slew_interpolator_macros.svh"

module multi_joint_slew_interpolator #(
    parameter int JOINTS      = 6,
    parameter int SOFT_MARGIN = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [59:0] i_cfg_data,
    // input words
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // joint_index[2:0], target_angle[12:3]
    input  wire logic [2:0]  i_s_axis_tuser,  // operation[2:0]
    // result words
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // servo_joint[2:0], servo_angle[12:3], moving[13], stopped[14],
    // read_angle[24:15], within_soft_limits[25]
    output logic [31:0]      o_m_axis_tdata,
    output logic [0:0]       o_m_axis_tuser,  // write_valid[0]
    output logic             o_m_axis_tlast
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic [3:0] JOINTS4 = 4'(JOINTS);
    localparam mjsi_pkg::t_wide MARGIN = 12'(SOFT_MARGIN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration registers
    logic [2:0]  r_count;
    logic [7:0]  r_step;
    logic [47:0] r_hmin;
    logic [47:0] r_hmax;
    logic [47:0] r_offs;
    logic [59:0] r_vel;

    // control
    logic [1:0]  r_state;
    logic        r_motion;
    logic        r_halt;
    logic        r_mode_move;
    logic [2:0]  r_idx;
    logic [2:0]  r_j;
    logic [2:0]  r_bcnt;
    logic [2:0]  r_e;
    logic        r_alleq;

    // angle memories
    mjsi_pkg::t_angle r_cur_mem [JOINTS];
    mjsi_pkg::t_angle r_tgt_mem [JOINTS];
    logic [JOINTS-1:0] r_cur_vld;
    logic [JOINTS-1:0] r_tgt_vld;
    mjsi_pkg::t_angle r_cur_q;
    mjsi_pkg::t_angle r_tgt_q;
    logic              r_cur_qv;
    logic              r_tgt_qv;

    // servo write buffer
    logic [2:0]       r_buf_joint [JOINTS];
    mjsi_pkg::t_angle r_buf_ang   [JOINTS];

    // output register
    logic             r_ovalid;
    logic             r_o_wv;
    logic [2:0]       r_o_joint;
    mjsi_pkg::t_angle r_o_angle;
    mjsi_pkg::t_angle r_o_rd;
    logic             r_o_within;
    logic             r_o_last;

    logic [2:0]       w_n;
    logic [2:0]       w_in_op;
    logic [2:0]       w_in_idx;
    mjsi_pkg::t_angle w_in_ang;
    logic             w_accept;
    logic             w_oload_ok;
    logic [3:0]       w_rd_sel;
    logic [JW-1:0]    w_raddr;
    logic             w_cur_we;
    mjsi_pkg::t_angle w_cur_wd;
    logic             w_tgt_we;
    mjsi_pkg::t_angle w_tgt_wd;
    logic [63:0]      w_hmin_x;
    logic [63:0]      w_hmax_x;

    // set target clamp
    mjsi_pkg::t_wide  w_set_hmin;
    mjsi_pkg::t_wide  w_set_hmax;
    mjsi_pkg::t_wide  w_set_a0;
    mjsi_pkg::t_wide  w_set_a1;
    mjsi_pkg::t_wide  w_set_a2;

    // sweep datapath
    mjsi_pkg::t_wide  w_c;
    mjsi_pkg::t_wide  w_t;
    mjsi_pkg::t_wide  w_d;
    mjsi_pkg::t_wide  w_lim;
    mjsi_pkg::t_wide  w_ms;
    mjsi_pkg::t_wide  w_st1;
    mjsi_pkg::t_wide  w_st2;
    mjsi_pkg::t_wide  w_newc;
    mjsi_pkg::t_wide  w_off;
    mjsi_pkg::t_wide  w_hw_raw;
    mjsi_pkg::t_wide  w_hw;
    mjsi_pkg::t_wide  w_move_ang;
    logic             w_run_end;

    // read datapath
    mjsi_pkg::t_wide  w_rd_smin;
    mjsi_pkg::t_wide  w_rd_smax;
    logic             w_rd_active;
    logic             w_rd_within;

    logic             w_emit_last;

    assign w_n      = (r_count > JOINTS4[2:0]) ? JOINTS4[2:0] : r_count;
    assign w_in_op  = i_s_axis_tuser;
    assign w_in_idx = i_s_axis_tdata[2:0];
    assign w_in_ang = i_s_axis_tdata[12:3];

    assign w_oload_ok      = !r_ovalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && w_oload_ok;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_hmin_x = {16'h0, r_hmin};
    assign w_hmax_x = {16'h0, r_hmax};

    // set target: hard clamp, then soft clamp, last clamp wins
    always_comb begin
        w_set_hmin = 12'(w_hmin_x[8*w_in_idx +: 8]);
        w_set_hmax = 12'(w_hmax_x[8*w_in_idx +: 8]);
        w_set_a0   = 12'(w_in_ang);
        if (w_set_a0 < w_set_hmin) begin
            w_set_a1 = w_set_hmin;
        end else if (w_set_a0 > w_set_hmax) begin
            w_set_a1 = w_set_hmax;
        end else begin
            w_set_a1 = w_set_a0;
        end
        if (w_set_a1 < w_set_hmin + MARGIN) begin
            w_set_a2 = w_set_hmin + MARGIN;
        end else if (w_set_a1 > w_set_hmax - MARGIN) begin
            w_set_a2 = w_set_hmax - MARGIN;
        end else begin
            w_set_a2 = w_set_a1;
        end
    end

    // read address: joint of a read at accept, next joint during the sweep
    always_comb begin
        if (r_state == S_RUN) begin
            w_rd_sel = 4'(r_j) + 4'd1;
        end else if (w_in_op == mjsi_pkg::OP_READ) begin
            w_rd_sel = 4'(w_in_idx);
        end else begin
            w_rd_sel = 4'd0;
        end
        w_raddr = (w_rd_sel < JOINTS4) ? w_rd_sel[JW-1:0] : '0;
    end

    // sweep step for joint r_j
    always_comb begin
        w_c   = 12'(r_cur_qv ? r_cur_q : mjsi_pkg::HOME_ANGLE);
        w_t   = 12'(r_tgt_qv ? r_tgt_q : mjsi_pkg::HOME_ANGLE);
        w_d   = w_t - w_c;
        w_lim = 12'(r_step);
        w_ms  = 12'(mjsi_pkg::frame_step(r_vel[10*r_j +: 10]));
        if (w_d > w_lim) begin
            w_st1 = w_lim;
        end else if (w_d < -w_lim) begin
            w_st1 = -w_lim;
        end else begin
            w_st1 = w_d;
        end
        if (w_st1 > w_ms) begin
            w_st2 = w_ms;
        end else if (w_st1 < -w_ms) begin
            w_st2 = -w_ms;
        end else begin
            w_st2 = w_st1;
        end
        w_newc   = w_c + w_st2;
        w_off    = 12'($signed(r_offs[8*r_j +: 8]));
        w_hw_raw = w_newc + w_off;
        if (w_hw_raw < 12'sd0) begin
            w_hw = 12'sd0;
        end else if (w_hw_raw > mjsi_pkg::SERVO_MAX) begin
            w_hw = mjsi_pkg::SERVO_MAX;
        end else begin
            w_hw = w_hw_raw;
        end
        w_move_ang = w_t + w_off;
        w_run_end  = (4'(r_j) + 4'd1) >= 4'(w_n);
    end

    // read result for r_idx
    always_comb begin
        w_rd_smin   = 12'(w_hmin_x[8*r_idx +: 8]) + MARGIN;
        w_rd_smax   = 12'(w_hmax_x[8*r_idx +: 8]) - MARGIN;
        w_rd_active = r_idx < w_n;
        w_rd_within = w_rd_active && (w_c >= w_rd_smin) && (w_c <= w_rd_smax);
    end

    assign w_emit_last = (r_bcnt == 3'd0) || ((r_e + 3'd1) == r_bcnt);

    // memory write controls
    always_comb begin
        w_tgt_we = w_accept && (w_in_op == mjsi_pkg::OP_SET_TARGET) && !r_halt &&
                   (w_in_idx < w_n);
        w_tgt_wd = w_set_a2[9:0];
        w_cur_we = (r_state == S_RUN) && (r_mode_move || (w_d != 12'sd0));
        w_cur_wd = r_mode_move ? w_t[9:0] : w_newc[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_cur_we) begin
            r_cur_mem[r_j[JW-1:0]] <= w_cur_wd;
        end
        if (w_tgt_we) begin
            r_tgt_mem[w_in_idx[JW-1:0]] <= w_tgt_wd;
        end
        r_cur_q <= r_cur_mem[w_raddr];
        r_tgt_q <= r_tgt_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= '0;
            r_tgt_vld <= '0;
            r_cur_qv  <= 1'b0;
            r_tgt_qv  <= 1'b0;
        end else begin
            if (w_cur_we) begin
                r_cur_vld[r_j[JW-1:0]] <= 1'b1;
            end
            if (w_tgt_we) begin
                r_tgt_vld[w_in_idx[JW-1:0]] <= 1'b1;
            end
            r_cur_qv <= r_cur_vld[w_raddr];
            r_tgt_qv <= r_tgt_vld[w_raddr];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_step  <= mjsi_pkg::STEP_RESET;
            r_hmin  <= '0;
            r_hmax  <= mjsi_pkg::HARD_MAX_RESET;
            r_offs  <= '0;
            r_vel   <= mjsi_pkg::VELOCITY_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mjsi_pkg::CFG_ACTIVE_COUNT: r_count <= i_cfg_data[2:0];
                mjsi_pkg::CFG_STEP_SIZE: begin
                    // a zero step is ignored
                    if (i_cfg_data[7:0] != 8'd0) begin
                        r_step <= i_cfg_data[7:0];
                    end
                end
                mjsi_pkg::CFG_HARD_MIN:   r_hmin <= i_cfg_data[47:0];
                mjsi_pkg::CFG_HARD_MAX:   r_hmax <= i_cfg_data[47:0];
                mjsi_pkg::CFG_OFFSETS:    r_offs <= i_cfg_data[47:0];
                mjsi_pkg::CFG_VELOCITIES: r_vel  <= i_cfg_data[59:0];
                default: ;
            endcase
        end
    end

    // servo write buffer
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RUN) && (r_mode_move || (w_d != 12'sd0))) begin
            r_buf_joint[r_bcnt[JW-1:0]] <= r_j;
            r_buf_ang[r_bcnt[JW-1:0]]   <= r_mode_move ? w_move_ang[9:0] : w_hw[9:0];
        end
    end

    // sequencer, flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_motion    <= 1'b0;
            r_halt      <= 1'b0;
            r_mode_move <= 1'b0;
            r_idx       <= 3'd0;
            r_j         <= 3'd0;
            r_bcnt      <= 3'd0;
            r_e         <= 3'd0;
            r_alleq     <= 1'b1;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx       <= w_in_idx;
                        r_j         <= 3'd0;
                        r_bcnt      <= 3'd0;
                        r_e         <= 3'd0;
                        r_alleq     <= 1'b1;
                        r_mode_move <= (w_in_op == mjsi_pkg::OP_MOVE_NOW);
                        // status word unless the item sweeps or reads
                        r_ovalid    <= 1'b1;
                        r_o_wv      <= 1'b0;
                        r_o_joint   <= 3'd0;
                        r_o_angle   <= '0;
                        r_o_rd      <= '0;
                        r_o_within  <= 1'b0;
                        r_o_last    <= 1'b1;
                        case (w_in_op)
                            mjsi_pkg::OP_SET_TARGET: begin
                                if (!r_halt && (w_in_idx < w_n)) begin
                                    r_motion <= 1'b1;
                                end
                            end
                            mjsi_pkg::OP_TICK: begin
                                if (r_motion && !r_halt) begin
                                    if (w_n == 3'd0) begin
                                        r_motion <= 1'b0;
                                    end else begin
                                        r_ovalid <= 1'b0;
                                        r_state  <= S_RUN;
                                    end
                                end
                            end
                            mjsi_pkg::OP_MOVE_NOW: begin
                                if (!r_halt) begin
                                    if (w_n == 3'd0) begin
                                        r_motion <= 1'b0;
                                    end else begin
                                        r_ovalid <= 1'b0;
                                        r_state  <= S_RUN;
                                    end
                                end
                            end
                            mjsi_pkg::OP_STOP: begin
                                r_halt   <= 1'b1;
                                r_motion <= 1'b0;
                            end
                            mjsi_pkg::OP_RELEASE: begin
                                r_halt <= 1'b0;
                            end
                            mjsi_pkg::OP_READ: begin
                                r_ovalid <= 1'b0;
                                r_state  <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    // output register is free here, accept needed it drained
                    r_ovalid   <= 1'b1;
                    r_o_wv     <= 1'b0;
                    r_o_joint  <= 3'd0;
                    r_o_angle  <= '0;
                    r_o_rd     <= w_rd_active ? w_c[9:0] : -10'sd1;
                    r_o_within <= w_rd_within;
                    r_o_last   <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_RUN: begin
                    if (r_mode_move || (w_d != 12'sd0)) begin
                        r_bcnt <= r_bcnt + 3'd1;
                    end
                    r_alleq <= r_alleq && (w_newc == w_t);
                    r_j     <= r_j + 3'd1;
                    if (w_run_end) begin
                        r_motion <= r_mode_move ? 1'b0 : !(r_alleq && (w_newc == w_t));
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_oload_ok) begin
                        r_ovalid   <= 1'b1;
                        r_o_rd     <= '0;
                        r_o_within <= 1'b0;
                        r_o_last   <= w_emit_last;
                        if (r_bcnt == 3'd0) begin
                            // every joint already at its target
                            r_o_wv    <= 1'b0;
                            r_o_joint <= 3'd0;
                            r_o_angle <= '0;
                        end else begin
                            r_o_wv    <= 1'b1;
                            r_o_joint <= r_buf_joint[r_e[JW-1:0]];
                            r_o_angle <= r_buf_ang[r_e[JW-1:0]];
                        end
                        r_e <= r_e + 3'd1;
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {6'd0, r_o_within, r_o_rd, r_halt, r_motion, r_o_angle, r_o_joint};
    assign o_m_axis_tuser  = r_o_wv;
    assign o_m_axis_tlast  = r_o_last;

    `MJSI_ASSERT(a_halt_clears_motion, i_clk, i_rst_n, !(r_halt && r_motion))
    `MJSI_ASSERT(a_sweep_output_empty, i_clk, i_rst_n, (r_state != S_RUN) || !r_ovalid)
    `MJSI_ASSERT(a_sweep_joint_range, i_clk, i_rst_n,
                 (r_state != S_RUN) || (4'(r_j) < JOINTS4))
    `MJSI_ASSERT(a_buffer_bound, i_clk, i_rst_n, 4'(r_bcnt) <= JOINTS4)
    `MJSI_ASSERT_NEXT(a_emit_done, i_clk, i_rst_n,
                      (r_state == S_EMIT) && w_oload_ok && w_emit_last,
                      (r_state == S_IDLE) && r_ovalid && r_o_last)

endmodule

`default_nettype wire
